// ===== src/fpm_pkg.sv =====
// Shared types and constants for the feathered polygon mesh generator.
package fpm_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_W          = 24;
  localparam int INDEX_W          = 5;
  localparam int CFG_W            = 16;
  localparam logic [CFG_W-1:0] FEATHER_LENGTH_RST = 16'd13107;
  localparam logic [CFG_W-1:0] FEATHER_LIMIT_RST  = 16'd13107;

  // configuration register indexes
  localparam logic REG_FEATHER_LENGTH = 1'b0;
  localparam logic REG_FEATHER_LIMIT  = 1'b1;

  // result kinds
  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  typedef enum logic [3:0] {
    A_IDLE, A_SQX, A_SQY, A_SQRT, A_DIV, A_SEL, A_SCX, A_SCY, A_DONE
  } arith_state_t;

  typedef enum logic [2:0] {
    T_IDLE, T_START, T_WAIT, T_EMIT, T_FAN, T_BORDER
  } seq_state_t;

  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } arith_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } arith_rsp_t;

endpackage

// ===== src/fpm_arith.sv =====
// Shared iterative unit: squares, bit-serial square root, division and scaling.
module fpm_arith (
  input  logic                          clk,
  input  logic                          rst,
  input  fpm_pkg::arith_req_t           req,
  input  logic [fpm_pkg::CFG_W-1:0]     feather_length,
  input  logic [fpm_pkg::CFG_W-1:0]     feather_limit,
  output fpm_pkg::arith_rsp_t           rsp
);

  fpm_pkg::arith_state_t state, state_next;

  logic [23:0] mx, my;
  logic        sx, sy;
  logic [47:0] rad;
  logic [25:0] rem;
  logic [23:0] root;
  logic [31:0] dvd;
  logic [31:0] quo;
  logic [4:0]  cnt;
  logic [16:0] scale;
  logic signed [23:0] ox, oy;

  // one multiplier
  logic [23:0] mul_a, mul_b;
  logic [47:0] prod;
  logic [23:0] sc_r;

  // one shared trial subtractor
  logic [27:0] sub_a, sub_b;
  logic [28:0] diff;
  logic        borrow;
  logic [25:0] rem_step;
  logic [15:0] m;

  always_comb begin
    mul_a = (state == fpm_pkg::A_SQX || state == fpm_pkg::A_SCX) ? mx : my;
    unique case (state)
      fpm_pkg::A_SQX: mul_b = mx;
      fpm_pkg::A_SQY: mul_b = my;
      default:        mul_b = {7'b0, scale};
    endcase
    prod = mul_a * mul_b;
    sc_r = prod[39:16];
  end

  always_comb begin
    if (state == fpm_pkg::A_SQRT) begin
      sub_a = {rem, rad[47:46]};
      sub_b = {2'b00, root, 2'b01};
    end else begin
      sub_a = {3'b000, rem[23:0], dvd[31]};
      sub_b = {4'b0000, root};
    end
    diff     = {1'b0, sub_a} - {1'b0, sub_b};
    borrow   = diff[28];
    rem_step = borrow ? sub_a[25:0] : diff[25:0];
    m        = (quo <= {16'b0, feather_limit}) ? quo[15:0] : feather_limit;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fpm_pkg::A_IDLE: if (req.start) state_next = fpm_pkg::A_SQX;
      fpm_pkg::A_SQX:  state_next = fpm_pkg::A_SQY;
      fpm_pkg::A_SQY:  state_next = fpm_pkg::A_SQRT;
      fpm_pkg::A_SQRT: if (cnt == 5'd23) state_next = fpm_pkg::A_DIV;
      fpm_pkg::A_DIV:  if (cnt == 5'd31) state_next = fpm_pkg::A_SEL;
      fpm_pkg::A_SEL:  state_next = fpm_pkg::A_SCX;
      fpm_pkg::A_SCX:  state_next = fpm_pkg::A_SCY;
      fpm_pkg::A_SCY:  state_next = fpm_pkg::A_DONE;
      fpm_pkg::A_DONE: state_next = fpm_pkg::A_IDLE;
      default:         state_next = fpm_pkg::A_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = (state == fpm_pkg::A_DONE);
    rsp.x    = ox;
    rsp.y    = oy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpm_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      fpm_pkg::A_IDLE: begin
        sx  <= req.x[23];
        sy  <= req.y[23];
        mx  <= req.x[23] ? 24'(-req.x) : 24'(req.x);
        my  <= req.y[23] ? 24'(-req.y) : 24'(req.y);
      end
      fpm_pkg::A_SQX: rad <= prod;
      fpm_pkg::A_SQY: begin
        rad  <= rad + prod;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end
      fpm_pkg::A_SQRT: begin
        root <= {root[22:0], ~borrow};
        rad  <= {rad[45:0], 2'b00};
        if (cnt == 5'd23) begin
          // the root remainder is not needed: the divider starts from zero
          rem <= '0;
          cnt <= '0;
          dvd <= {feather_length, 16'b0};
          quo <= '0;
        end else begin
          rem <= rem_step;
          cnt <= cnt + 5'd1;
        end
      end
      fpm_pkg::A_DIV: begin
        rem <= rem_step;
        quo <= {quo[30:0], ~borrow};
        dvd <= {dvd[30:0], 1'b0};
        cnt <= cnt + 5'd1;
      end
      fpm_pkg::A_SEL: scale <= 17'h10000 - {1'b0, m};
      fpm_pkg::A_SCX: ox <= sx ? -$signed(sc_r) : $signed(sc_r);
      fpm_pkg::A_SCY: oy <= sy ? -$signed(sc_r) : $signed(sc_r);
      default: ;
    endcase
  end

endmodule

// ===== src/feathered_polygon_mesh_gen.sv =====
// Top level: vertex store, mesh sequencer and output register.
//
// Usage. Vertices of a convex polygon enter on the input channel (in_valid /
// in_stall, beat accepted when valid and not stall), last_vertex set on the
// final one. Each stored vertex is echoed as an outer vertex in the cycle
// after it is accepted. On the final vertex the block emits one inner vertex
// per stored vertex, then the inner fan triangles, then two border triangles
// per edge; the final result carries last_result. Vertices beyond
// MAX_VERTICES are dropped and flagged on overflow. Each inner vertex is
// computed in the shared unit (two squares, 24 root steps, 32 divide steps,
// select, two scalings, handback), started by the sequencer and then
// emitted. Then come N-2 fan triangles (none below three vertices), a pause
// with no output and 2N border triangles, one per cycle unless out_stall
// holds the output register. The input is stalled meanwhile. Results sit in
// one output register; out_stall holds it and the sequencer waits to load
// the next result. Configuration (cfg_valid / cfg_ready, always ready) must
// be written only while idle; the block itself does not enforce it. Reset
// (rst, synchronous) empties the store and restores the default feather length and limit.
module feathered_polygon_mesh_gen #(
  parameter int MAX_VERTICES = fpm_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fpm_pkg::COORD_W-1:0] vertex_x,
  input  logic signed [fpm_pkg::COORD_W-1:0] vertex_y,
  input  logic                              last_vertex,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              kind,
  output logic signed [fpm_pkg::COORD_W-1:0] pos_x,
  output logic signed [fpm_pkg::COORD_W-1:0] pos_y,
  output logic                              alpha,
  output logic [fpm_pkg::INDEX_W-1:0]       index_a,
  output logic [fpm_pkg::INDEX_W-1:0]       index_b,
  output logic [fpm_pkg::INDEX_W-1:0]       index_c,
  output logic                              overflow,
  output logic                              last_result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [fpm_pkg::CFG_W-1:0]         cfg_data
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int IW = fpm_pkg::INDEX_W;

  fpm_pkg::seq_state_t state, state_next;

  logic signed [fpm_pkg::COORD_W-1:0] store_x [MAX_VERTICES];
  logic signed [fpm_pkg::COORD_W-1:0] store_y [MAX_VERTICES];

  logic [IW-1:0] vertex_count;
  logic          overflow_flag;
  logic [IW-1:0] n;
  logic [IW-1:0] idx;
  logic          sub;
  logic [fpm_pkg::CFG_W-1:0] feather_length, feather_limit;

  fpm_pkg::arith_req_t req;
  fpm_pkg::arith_rsp_t rsp;

  logic out_free, out_load, in_acc, room, fan_more, last_idx;
  logic [IW-1:0] nxt, count_after;

  fpm_arith u_arith (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .feather_length (feather_length),
    .feather_limit  (feather_limit),
    .rsp            (rsp)
  );

  always_comb begin
    out_free    = !out_valid || !out_stall;
    in_stall    = !(state == fpm_pkg::T_IDLE && out_free);
    in_acc      = in_valid && !in_stall;
    room        = vertex_count < IW'(MAX_VERTICES);
    count_after = room ? vertex_count + IW'(1) : vertex_count;
    fan_more    = ({1'b0, idx} + 6'd1) < {n, 1'b0};
    last_idx    = (idx == n - IW'(1));
    nxt         = last_idx ? '0 : idx + IW'(1);
    cfg_ready   = 1'b1;
    req.start   = (state == fpm_pkg::T_START);
    req.x       = store_x[idx[AW-1:0]];
    req.y       = store_y[idx[AW-1:0]];
    // a new beat enters the output register this cycle
    out_load    = out_free && ((state == fpm_pkg::T_IDLE && in_acc && room) ||
                               state == fpm_pkg::T_EMIT ||
                               (state == fpm_pkg::T_FAN && fan_more) ||
                               state == fpm_pkg::T_BORDER);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fpm_pkg::T_IDLE:   if (in_acc && last_vertex) state_next = fpm_pkg::T_START;
      fpm_pkg::T_START:  state_next = fpm_pkg::T_WAIT;
      fpm_pkg::T_WAIT:   if (rsp.done) state_next = fpm_pkg::T_EMIT;
      fpm_pkg::T_EMIT:   if (out_free) state_next = last_idx ? fpm_pkg::T_FAN
                                                            : fpm_pkg::T_START;
      fpm_pkg::T_FAN:    if (!fan_more) state_next = fpm_pkg::T_BORDER;
      fpm_pkg::T_BORDER: if (out_free && sub && last_idx) state_next = fpm_pkg::T_IDLE;
      default:           state_next = fpm_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpm_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      feather_length <= fpm_pkg::FEATHER_LENGTH_RST;
      feather_limit  <= fpm_pkg::FEATHER_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpm_pkg::REG_FEATHER_LENGTH: feather_length <= cfg_data;
        fpm_pkg::REG_FEATHER_LIMIT:  feather_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // vertex store
  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      store_x[vertex_count[AW-1:0]] <= vertex_x;
      store_y[vertex_count[AW-1:0]] <= vertex_y;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= '0;
      overflow_flag <= 1'b0;
      idx           <= '0;
      sub           <= 1'b0;
      n             <= '0;
    end else begin
      unique case (state)
        fpm_pkg::T_IDLE: begin
          if (in_acc) begin
            vertex_count <= count_after;
            if (!room) overflow_flag <= 1'b1;
            n   <= count_after;
            idx <= '0;
          end
        end
        fpm_pkg::T_EMIT: begin
          if (out_free) idx <= last_idx ? n + IW'(1) : idx + IW'(1);
        end
        fpm_pkg::T_FAN: begin
          if (!fan_more) begin
            idx <= '0;
            sub <= 1'b0;
          end else if (out_free) begin
            idx <= idx + IW'(1);
          end
        end
        fpm_pkg::T_BORDER: begin
          if (out_free) begin
            sub <= !sub;
            if (sub) idx <= nxt;
            if (sub && last_idx) begin
              vertex_count  <= '0;
              overflow_flag <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      fpm_pkg::T_IDLE: begin
        if (in_acc && room) begin
          kind <= fpm_pkg::KIND_VERTEX;  pos_x <= vertex_x; pos_y <= vertex_y;
          alpha <= 1'b0; index_a <= '0; index_b <= '0; index_c <= '0;
          overflow <= overflow_flag; last_result <= 1'b0;
        end
      end
      fpm_pkg::T_EMIT: begin
        if (out_free) begin
          kind <= fpm_pkg::KIND_VERTEX;  pos_x <= rsp.x; pos_y <= rsp.y;
          alpha <= 1'b1; index_a <= '0; index_b <= '0; index_c <= '0;
          overflow <= overflow_flag; last_result <= 1'b0;
        end
      end
      fpm_pkg::T_FAN: begin
        if (out_free && fan_more) begin
          kind <= fpm_pkg::KIND_TRIANGLE; pos_x <= '0; pos_y <= '0; alpha <= 1'b0;
          index_a <= n; index_b <= idx; index_c <= idx + IW'(1);
          overflow <= overflow_flag; last_result <= 1'b0;
        end
      end
      fpm_pkg::T_BORDER: begin
        if (out_free) begin
          kind <= fpm_pkg::KIND_TRIANGLE; pos_x <= '0; pos_y <= '0; alpha <= 1'b0;
          index_a <= sub ? idx + n : idx;
          index_b <= nxt;
          index_c <= sub ? nxt + n : idx + n;
          overflow <= overflow_flag; last_result <= sub && last_idx;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the feathered polygon mesh generator.
`timescale 1ns / 100ps

module tb;

  localparam int NV         = 16;
  localparam int LIMIT      = 400000;
  localparam int HOLD_AT    = 40;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic              kind;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic              alpha;
    logic [4:0]        ia;
    logic [4:0]        ib;
    logic [4:0]        ic;
    logic              ovf;
    logic              fin;
  } mesh_beat_t;

  // Mesh predictor and store of pending beats
  class mesh_board;
    int                 sx[NV];
    int                 sy[NV];
    int unsigned        count;
    bit                 ovf;
    logic [15:0]        flen;
    logic [15:0]        flim;
    mesh_beat_t         pending[$];
    int                 errors;

    function void clear();
      count = 0;
      ovf = 0;
      flen = fpm_pkg::FEATHER_LENGTH_RST;
      flim = fpm_pkg::FEATHER_LIMIT_RST;
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == fpm_pkg::REG_FEATHER_LENGTH) flen = val;
      else flim = val;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function logic signed [23:0] shrink(longint c, longint unsigned s);
      longint unsigned mag, r;
      mag = (c < 0) ? -c : c;
      r = (mag * s) >> 16;
      return 24'((c < 0) ? -longint'(r) : longint'(r));
    endfunction

    function void add_beat(logic k, logic signed [23:0] x, logic signed [23:0] y,
                           logic a, int unsigned i0, int unsigned i1, int unsigned i2);
      mesh_beat_t e;
      e.kind = k; e.px = x; e.py = y; e.alpha = a;
      e.ia = 5'(i0); e.ib = 5'(i1); e.ic = 5'(i2); e.ovf = ovf; e.fin = 1'b0;
      pending.insert(pending.size(), e);
    endfunction

    // Accepted vertex: echo, and on the last one the whole mesh
    function void note_vertex(logic signed [23:0] x, logic signed [23:0] y, bit last);
      int unsigned n, nx;
      longint vx, vy;
      longint unsigned len, m, ratio, sc;
      if (count < NV) begin
        sx[count] = int'(x);
        sy[count] = int'(y);
        count++;
        add_beat(fpm_pkg::KIND_VERTEX, x, y, 1'b0, 0, 0, 0);
      end else begin
        ovf = 1;
      end
      if (!last) return;
      n = count;
      for (int unsigned i = 0; i < n; i++) begin
        vx = sx[i];
        vy = sy[i];
        len = root(longint'(vx * vx) + longint'(vy * vy));
        m = flim;
        if (len != 0) begin
          ratio = (longint'(flen) << 16) / len;
          if (ratio <= m) m = ratio;
        end
        sc = 65536 - m;
        add_beat(fpm_pkg::KIND_VERTEX, shrink(vx, sc), shrink(vy, sc), 1'b1, 0, 0, 0);
      end
      for (int unsigned i = n + 1; i + 1 < 2 * n; i++)
        add_beat(fpm_pkg::KIND_TRIANGLE, '0, '0, 1'b0, n, i, i + 1);
      for (int unsigned i = 0; i < n; i++) begin
        nx = (i + 1) % n;
        add_beat(fpm_pkg::KIND_TRIANGLE, '0, '0, 1'b0, i, nx, i + n);
        add_beat(fpm_pkg::KIND_TRIANGLE, '0, '0, 1'b0, i + n, nx, nx + n);
      end
      if (pending.size() > 0) pending[pending.size() - 1].fin = 1'b1;
      count = 0;
      ovf = 0;
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s mismatch: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_beat(mesh_beat_t got);
      mesh_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat, kind %0d", got.kind);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("kind", e.kind, got.kind);
      cmp("pos_x", e.px, got.px);
      cmp("pos_y", e.py, got.py);
      cmp("alpha", e.alpha, got.alpha);
      cmp("index_a", e.ia, got.ia);
      cmp("index_b", e.ib, got.ib);
      cmp("index_c", e.ic, got.ic);
      cmp("overflow", e.ovf, got.ovf);
      cmp("last_result", e.fin, got.fin);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [23:0] vertex_x = 0;
  logic signed [23:0] vertex_y = 0;
  logic last_vertex = 0;
  logic out_valid;
  logic out_stall = 0;
  logic kind, alpha, overflow, last_result;
  logic signed [23:0] pos_x, pos_y;
  logic [4:0] index_a, index_b, index_c;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = fpm_pkg::REG_FEATHER_LENGTH;
  logic [15:0] cfg_data = 0;

  mesh_board board = new();
  int cycles = 0;
  int results = 0;
  int hold = 0;
  bit send_burst = 0;
  bit recv_burst = 0;

  always #6 clk = ~clk;

  feathered_polygon_mesh_gen uut (.*);

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result monitor: check each beat and pick the next stall length
  always @(posedge clk) begin
    mesh_beat_t got;
    if (!rst && out_valid && !out_stall) begin
      got.kind = kind; got.px = pos_x; got.py = pos_y; got.alpha = alpha;
      got.ia = index_a; got.ib = index_b; got.ic = index_c;
      got.ovf = overflow; got.fin = last_result;
      board.check_beat(got);
      results++;
      if ($urandom_range(0, 15) == 0) recv_burst = ~recv_burst;
      hold = recv_burst ? 0 : $urandom_range(0, 5);
      if (results == HOLD_AT) hold = HOLD_LEN;
    end
  end

  // Receiver stall, counted in cycles
  always @(negedge clk) begin
    if (hold > 0) begin
      out_stall <= 1;
      hold = hold - 1;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send_vertex(int x, int y, bit last);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    vertex_x <= 24'(x);
    vertex_y <= 24'(y);
    last_vertex <= last;
    do @(posedge clk); while (in_stall);
    board.note_vertex(24'(x), 24'(y), last);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Drain: every pending beat seen, then let the sequencer settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic int rand_coord(int mode);
    case (mode)
      0: return int'($urandom_range(0, 24'hFFFFFF));
      1: return int'($urandom_range(0, 20'hFFFFF)) - 20'h80000;
      default: return int'($urandom_range(0, 16'hFFFF)) - 16'h8000;
    endcase
  endfunction

  function automatic int sx24(int v);
    return (v << 8) >>> 8;
  endfunction

  // One polygon of n vertices, last marked on the final one
  task automatic polygon(int n);
    int mode;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_vertex(0, 0, i == n - 1);
      else
        send_vertex(sx24(rand_coord(mode)), sx24(rand_coord(mode)), i == n - 1);
    end
  endtask

  int sent;
  int n;
  initial begin
    board.clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: extreme coordinates, tiny polygons, zero vertex, overflow
    send_vertex(8388607, -8388608, 1);
    send_vertex(0, 0, 0);
    send_vertex(-8388608, 8388607, 1);
    send_vertex(0, 0, 0);
    send_vertex(65536, 0, 0);
    send_vertex(-1, -1, 1);
    for (int i = 0; i < 18; i++)
      send_vertex(sx24(rand_coord(0)), sx24(rand_coord(0)), i == 17);
    drain();

    // Random phases across register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(fpm_pkg::REG_FEATHER_LENGTH, 0);
                 write_reg(fpm_pkg::REG_FEATHER_LIMIT, 0); end
        1: begin write_reg(fpm_pkg::REG_FEATHER_LENGTH, 16'hFFFF);
                 write_reg(fpm_pkg::REG_FEATHER_LIMIT, 16'hFFFF); end
        2: begin write_reg(fpm_pkg::REG_FEATHER_LENGTH, 16'hFFFF);
                 write_reg(fpm_pkg::REG_FEATHER_LIMIT, 0); end
        3: begin write_reg(fpm_pkg::REG_FEATHER_LENGTH, 0);
                 write_reg(fpm_pkg::REG_FEATHER_LIMIT, 16'hFFFF); end
        default: begin
          write_reg(fpm_pkg::REG_FEATHER_LENGTH, 16'($urandom_range(0, 16'hFFFF)));
          write_reg(fpm_pkg::REG_FEATHER_LIMIT, 16'($urandom_range(0, 16'hFFFF)));
        end
      endcase
      sent = 0;
      while (sent < 66) begin
        case ($urandom_range(0, 9))
          0: n = $urandom_range(1, 2);
          1: n = $urandom_range(17, 20);
          default: n = $urandom_range(3, 16);
        endcase
        polygon(n);
        sent += n;
      end
      drain();
    end

    if (board.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/fpm_pkg.sv
src/fpm_arith.sv
src/feathered_polygon_mesh_gen.sv
test/tb.sv
